// ===== rtl/sorted_priority_queue_macros.svh =====
// Assertion macros for the sorted priority queue
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/spq_pkg.sv =====
// Package: types and constants shared by the sorted priority queue
`timescale 1ns / 1ps
package spq_pkg;

  localparam int DEPTH     = 16;
  localparam int KEY_WIDTH = 32;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int IDX_W     = $clog2(DEPTH);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_POP    = 2'd2
  } spq_op_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_EMPTY   = 2'd2,
    STAT_MISSING = 2'd3
  } spq_status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } spq_state_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] value;
  } spq_in_t;

  typedef struct packed {
    logic signed [31:0] popped_value;
    logic [1:0]         status;
    logic [4:0]         occupancy;
  } spq_out_t;

  typedef struct packed {
    logic load;
    logic exec;
  } spq_cmd_t;

endpackage

// ===== rtl/spq_controller.sv =====
// Controller: sequences capture and execution of one operation
`timescale 1ns / 1ps
module spq_controller import spq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  output spq_cmd_t cmd_o
);

  spq_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.load = 1'b0;
    cmd_o.exec = 1'b0;
    busy       = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        busy       = 1'b1;
        cmd_o.exec = 1'b1;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/spq_datapath.sv =====
// Datapath: sorted key cells with parallel compare, count and result register
`timescale 1ns / 1ps
module spq_datapath import spq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  spq_cmd_t cmd_i,
  input  spq_in_t  in_i,
  output logic     result_valid_o,
  output spq_out_t result_o
);

  spq_in_t                    in_q;
  logic signed [KEY_WIDTH-1:0] entries_q [DEPTH];
  logic signed [KEY_WIDTH-1:0] entries_d [DEPTH];
  logic [CNT_W-1:0]           count_q, count_d;
  logic                       valid_q;
  spq_out_t                   out_q, out_d;

  logic signed [KEY_WIDTH-1:0] key;
  logic [DEPTH-1:0]           cell_valid, cell_gt, cell_ge, cell_eq;
  logic                       full, empty, found, take_prev, place;
  logic signed [KEY_WIDTH-1:0] top_entry;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q <= in_i;
    end
  end

  assign key       = in_q.value[KEY_WIDTH-1:0];
  assign full      = (count_q == CNT_W'(DEPTH));
  assign empty     = (count_q == '0);
  assign found     = |cell_eq;
  assign top_entry = entries_q[IDX_W'(count_q - CNT_W'(1))];

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_valid[i] = (count_q > CNT_W'(i));
      cell_gt[i]    = cell_valid[i] && (entries_q[i] > key);
      cell_ge[i]    = cell_valid[i] && (entries_q[i] >= key);
      cell_eq[i]    = cell_valid[i] && (entries_q[i] == key);
    end
  end

  always_comb begin
    take_prev = 1'b0;
    place     = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      entries_d[i] = entries_q[i];
    end
    count_d = count_q;
    out_d   = '{popped_value: '0, status: STAT_OK, occupancy: '0};
    case (spq_op_e'(in_q.opcode))
      OP_INSERT: begin
        if (full) begin
          out_d.status = STAT_FULL;
        end else begin
          for (int i = 0; i < DEPTH; i++) begin
            take_prev = (i > 0) && cell_gt[(i > 0) ? i - 1 : 0];
            place     = !take_prev && (cell_gt[i] || (count_q == CNT_W'(i)));
            if (take_prev) begin
              entries_d[i] = entries_q[(i > 0) ? i - 1 : 0];
            end else if (place) begin
              entries_d[i] = key;
            end
          end
          count_d = count_q + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (!found) begin
          out_d.status = STAT_MISSING;
        end else begin
          for (int i = 0; i < DEPTH - 1; i++) begin
            if (cell_ge[i]) begin
              entries_d[i] = entries_q[i + 1];
            end
          end
          count_d = count_q - CNT_W'(1);
        end
      end
      OP_POP: begin
        if (empty) begin
          out_d.status = STAT_EMPTY;
        end else begin
          out_d.popped_value = 32'(top_entry);
          count_d            = count_q - CNT_W'(1);
        end
      end
      default: begin
        out_d.status = STAT_OK;
      end
    endcase
    out_d.occupancy = 5'(count_d);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      for (int i = 0; i < DEPTH; i++) begin
        entries_q[i] <= entries_d[i];
      end
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.exec;
      if (cmd_i.exec) begin
        count_q <= count_d;
      end
    end
  end

  assign result_valid_o = valid_q;
  assign result_o       = out_q;

endmodule

// ===== rtl/sorted_priority_queue.sv =====
// A transfer at start is executed in the next cycle; its result strobes in the cycle after execution.
// A new transfer is taken only while idle, after the capture then execute sequence of the last one.
// All compares and shifts over the 16 key cells happen in the execute cycle.
// Reset: asynchronous, active low; clears the occupancy count and control, keys stay undefined.
// Results are not held off: each is shown for one cycle with result_valid_o.
`timescale 1ns / 1ps
module sorted_priority_queue import spq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  spq_in_t  cmd_i,
  output logic     busy,
  output logic     result_valid_o,
  output spq_out_t result_o
);

  spq_cmd_t ctrl_cmd;

  spq_controller u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (ctrl_cmd)
  );

  spq_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (ctrl_cmd),
    .in_i           (cmd_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

// ===== rtl/spq_checker.sv =====
// Checker: port-level assertions for the sorted priority queue, bound to the top level
`timescale 1ns / 1ps
`include "sorted_priority_queue_macros.svh"
module spq_checker import spq_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input spq_in_t  cmd_i,
  input logic     busy,
  input logic     result_valid_o,
  input spq_out_t result_o
);

  `SPQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !result_valid_o, "transfer did not raise busy")
  `SPQ_ASSERT_NEXT(a_busy_result, busy, result_valid_o && !busy, "no result after execute")
  `SPQ_ASSERT_NOW(a_full_occ, result_valid_o && result_o.status == STAT_FULL, result_o.occupancy == 5'(DEPTH), "full status with room left")
  `SPQ_ASSERT_NOW(a_empty_pop, result_valid_o && result_o.status == STAT_EMPTY, result_o.occupancy == '0 && result_o.popped_value == '0, "empty pop with data")

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);

// ===== dv/tb_sorted_priority_queue.sv =====
// Self-checking testbench for the sorted priority queue: directed table, then random operations
`timescale 1ns / 1ps
module tb_sorted_priority_queue;
  import spq_pkg::*;

  localparam logic [1:0] OP_UNUSED      = 2'd3;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         RANDOM_PHASES  = 6;
  localparam int         PHASE_ITEMS    = 100;
  localparam int         POOL_SIZE      = 8;
  localparam int         INSERT_PCT [RANDOM_PHASES] = '{70, 25, 50, 90, 10, 50};
  localparam logic [31:0] KEY_EXTREMES [4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] value;
    logic [7:0]  reps;
    logic        pinned;
    spq_out_t    result;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 25;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{OP_POP,    32'h0000_0000, 8'd1,  1'b1, '{32'sd0, STAT_EMPTY, 5'd0}},
    '{OP_REMOVE, 32'h0000_0005, 8'd1,  1'b1, '{32'sd0, STAT_MISSING, 5'd0}},
    '{OP_UNUSED, 32'hFFFF_FFFF, 8'd1,  1'b1, '{32'sd0, STAT_OK, 5'd0}},
    '{OP_INSERT, 32'h7FFF_FFFF, 8'd1,  1'b1, '{32'sd0, STAT_OK, 5'd1}},
    '{OP_INSERT, 32'h8000_0000, 8'd1,  1'b1, '{32'sd0, STAT_OK, 5'd2}},
    '{OP_INSERT, 32'h0000_0000, 8'd1,  1'b0, '0},
    '{OP_INSERT, 32'hFFFF_FFFF, 8'd1,  1'b0, '0},
    '{OP_INSERT, 32'h0000_0001, 8'd1,  1'b0, '0},
    '{OP_INSERT, 32'h0000_0000, 8'd1,  1'b0, '0},
    '{OP_INSERT, 32'h7FFF_FFFF, 8'd1,  1'b0, '0},
    '{OP_POP,    32'h1234_5678, 8'd1,  1'b1, '{32'sh7FFF_FFFF, STAT_OK, 5'd6}},
    '{OP_POP,    32'h0000_0000, 8'd1,  1'b1, '{32'sh7FFF_FFFF, STAT_OK, 5'd5}},
    '{OP_REMOVE, 32'h0000_0000, 8'd1,  1'b0, '0},
    '{OP_REMOVE, 32'h8000_0000, 8'd1,  1'b0, '0},
    '{OP_REMOVE, 32'h0000_3039, 8'd1,  1'b1, '{32'sd0, STAT_MISSING, 5'd3}},
    '{OP_INSERT, 32'h5555_AAAA, 8'd13, 1'b0, '0},
    '{OP_INSERT, 32'hAAAA_5555, 8'd1,  1'b1, '{32'sd0, STAT_FULL, 5'd16}},
    '{OP_UNUSED, 32'h0000_0000, 8'd1,  1'b1, '{32'sd0, STAT_OK, 5'd16}},
    '{OP_REMOVE, 32'h0000_0001, 8'd1,  1'b0, '0},
    '{OP_INSERT, 32'h8000_0000, 8'd1,  1'b0, '0},
    '{OP_POP,    32'hFFFF_FFFF, 8'd1,  1'b1, '{32'sh5555_AAAA, STAT_OK, 5'd15}},
    '{OP_REMOVE, 32'hFFFF_FFFF, 8'd1,  1'b0, '0},
    '{OP_POP,    32'h0000_0000, 8'd14, 1'b0, '0},
    '{OP_POP,    32'h0000_0000, 8'd1,  1'b1, '{32'sd0, STAT_EMPTY, 5'd0}},
    '{OP_REMOVE, 32'h8000_0000, 8'd1,  1'b1, '{32'sd0, STAT_MISSING, 5'd0}}
  };

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  spq_in_t  cmd_i;
  logic     busy;
  logic     result_valid_o;
  spq_out_t result_o;

  logic     pin_valid;
  spq_out_t pin_result;

  logic signed [KEY_WIDTH-1:0] model_keys [DEPTH];
  int       model_count;
  spq_out_t expected_results [$];
  int       mismatch_count;
  int       idle_cycles;

  sorted_priority_queue DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .cmd_i          (cmd_i),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic spq_out_t apply_queue_op(spq_in_t item);
    spq_out_t                    res;
    int                          pos;
    logic signed [KEY_WIDTH-1:0] key;
    key    = item.value[KEY_WIDTH-1:0];
    res    = '0;
    res.status = STAT_OK;
    case (item.opcode)
      OP_INSERT: begin
        if (model_count >= DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          pos = model_count;
          for (int i = model_count - 1; i >= 0; i--) begin
            if (model_keys[i] > key) pos = i;
          end
          for (int i = model_count; i > pos; i--) model_keys[i] = model_keys[i-1];
          model_keys[pos] = key;
          model_count++;
        end
      end
      OP_REMOVE: begin
        pos = -1;
        for (int i = model_count - 1; i >= 0; i--) begin
          if (model_keys[i] == key) pos = i;
        end
        if (pos < 0) begin
          res.status = STAT_MISSING;
        end else begin
          for (int i = pos; i + 1 < model_count; i++) model_keys[i] = model_keys[i+1];
          model_count--;
        end
      end
      OP_POP: begin
        if (model_count == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          res.popped_value = model_keys[model_count-1];
          model_count--;
        end
      end
      default: ;
    endcase
    res.occupancy = 5'(model_count);
    return res;
  endfunction

  always @(posedge clk_i) begin
    spq_out_t exp_res;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with none expected: expected none actual %p", $time, result_o);
          mismatch_count++;
        end else begin
          exp_res = expected_results.pop_front();
          if (result_o.popped_value !== exp_res.popped_value) begin
            $display("%0t: popped_value expected %h actual %h", $time,
                     exp_res.popped_value, result_o.popped_value);
            mismatch_count++;
          end
          if (result_o.status !== exp_res.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     exp_res.status, result_o.status);
            mismatch_count++;
          end
          if (result_o.occupancy !== exp_res.occupancy) begin
            $display("%0t: occupancy expected %0d actual %0d", $time,
                     exp_res.occupancy, result_o.occupancy);
            mismatch_count++;
          end
        end
      end
      if (start && !busy) begin
        exp_res = apply_queue_op(cmd_i);
        if (pin_valid) exp_res = pin_result;
        expected_results.push_back(exp_res);
      end
      if ((start && !busy) || result_valid_o) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, no transfer in %0d cycles", $time, idle_cycles);
        $display("FAIL sorted_priority_queue");
        $finish;
      end
    end
  end

  function automatic int pick_gap(bit idle_on);
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic send_item(logic [1:0] op, logic [31:0] val, logic pinned, spq_out_t res,
                           int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start      <= 1'b1;
    cmd_i      <= '{opcode: op, value: val};
    pin_valid  <= pinned;
    pin_result <= res;
    do @(posedge clk_i); while (busy);
  endtask

  initial begin
    logic [31:0] key_pool [POOL_SIZE];
    logic [1:0]  op;
    logic [31:0] val;
    int          r;
    bit          idle_on;
    rst_ni         = 1'b0;
    start          = 1'b0;
    cmd_i          = '0;
    pin_valid      = 1'b0;
    pin_result     = '0;
    model_count    = 0;
    mismatch_count = 0;
    idle_cycles    = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int row = 0; row < DIRECTED_ROWS; row++) begin
      for (int n = 0; n < DIRECTED[row].reps; n++) begin
        send_item(DIRECTED[row].op, DIRECTED[row].value,
                  DIRECTED[row].pinned && (DIRECTED[row].reps == 1),
                  DIRECTED[row].result, pick_gap(1'b1));
      end
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      idle_on = (ph % 3) != 1;
      for (int k = 0; k < POOL_SIZE; k++) begin
        key_pool[k] = ($urandom_range(0, 3) == 0) ? KEY_EXTREMES[$urandom_range(0, 3)]
                                                   : $urandom;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < INSERT_PCT[ph]) op = OP_INSERT;
        else if (r >= 98) op = OP_UNUSED;
        else if (r < INSERT_PCT[ph] + (100 - INSERT_PCT[ph]) / 2) op = OP_REMOVE;
        else op = OP_POP;
        val = ($urandom_range(0, 3) != 0) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                          : $urandom;
        send_item(op, val, 1'b0, '0, pick_gap(idle_on));
      end
    end
    start <= 1'b0;

    wait (expected_results.size() == 0);
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS sorted_priority_queue");
    end else begin
      $display("FAIL sorted_priority_queue");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_controller.sv
rtl/spq_datapath.sv
rtl/sorted_priority_queue.sv
rtl/spq_checker.sv
dv/tb_sorted_priority_queue.sv
